[hdl/chacha_pkg.sv]
// Types, constants and microcode program for the ChaCha keystream block.
`default_nettype none

package chacha_pkg;

   localparam int WORD_COUNT          = 16;
   localparam int PAIR_COUNT          = 8;
   localparam int LANE_COUNT          = 4;
   localparam int DEFAULT_ROUND_COUNT = 20;
   localparam int STEP_BITS           = 3;
   localparam int CSR_ADDR_BITS       = 6;

   localparam logic [31:0] SIGMA_WORDS [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   // register indexes on the csr port (8 bytes apart)
   localparam logic [2:0] REG_KEY_0_1 = 3'd0;
   localparam logic [2:0] REG_KEY_2_3 = 3'd1;
   localparam logic [2:0] REG_KEY_4_5 = 3'd2;
   localparam logic [2:0] REG_KEY_6_7 = 3'd3;
   localparam logic [2:0] REG_NONCE   = 3'd4;

   typedef logic [STEP_BITS-1:0] step_type;

   typedef enum logic [2:0] {
      OP_MIX_A,
      OP_MIX_B,
      OP_FINAL,
      OP_EMIT,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ROUND_DONE,
      JMP_ROUND_LEFT,
      JMP_PAIR_LEFT
   } jump_type;

   typedef struct packed {
      op_type   op;
      logic     diag;
      logic     dec_round;
      jump_type jump;
      step_type target;
   } ctrl_type;

   localparam step_type STEP_COL_A  = 3'd0;
   localparam step_type STEP_COL_B  = 3'd1;
   localparam step_type STEP_DIAG_A = 3'd2;
   localparam step_type STEP_DIAG_B = 3'd3;
   localparam step_type STEP_FINAL  = 3'd4;
   localparam step_type STEP_EMIT   = 3'd5;
   localparam step_type STEP_END    = 3'd6;

   // microcode: one control word per step
   function automatic ctrl_type microcode(step_type step);
      ctrl_type cw;
      unique case (step)
         STEP_COL_A:  cw = '{OP_MIX_A,  1'b0, 1'b0, JMP_NONE,       STEP_COL_A};
         STEP_COL_B:  cw = '{OP_MIX_B,  1'b0, 1'b1, JMP_ROUND_DONE, STEP_FINAL};
         STEP_DIAG_A: cw = '{OP_MIX_A,  1'b1, 1'b0, JMP_NONE,       STEP_COL_A};
         STEP_DIAG_B: cw = '{OP_MIX_B,  1'b1, 1'b1, JMP_ROUND_LEFT, STEP_COL_A};
         STEP_FINAL:  cw = '{OP_FINAL,  1'b0, 1'b0, JMP_NONE,       STEP_COL_A};
         STEP_EMIT:   cw = '{OP_EMIT,   1'b0, 1'b0, JMP_PAIR_LEFT,  STEP_EMIT};
         default:     cw = '{OP_FINISH, 1'b0, 1'b0, JMP_NONE,       STEP_COL_A};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

[hdl/chacha20_block_keystream.sv]
// ChaCha block function keystream generator, microcoded, top level.
`default_nettype none

// ChaCha20 keystream block.
// Load the key (four 64-bit registers) and the nonce over the register port,
// then pulse start with a 64-bit block number while busy is low. The block
// builds the 16-word state, runs ROUND_COUNT rounds and adds the start state
// back, then puts out eight 64-bit words, one per cycle on consecutive cycles,
// each marked by rsp_valid for exactly one cycle: pair 0 first (keystream
// word 0 in the low half), rsp_last_pair on pair 7. The receiver cannot stall
// these; it must take each word in the cycle it is shown.
// Busy stays high until the last word is out; a new block is taken only
// when busy is low. The block has a single quarter-round unit: four lanes
// do one half of a quarter-round per cycle, a round being the MIX_A step
// then the MIX_B step, under a small microcode program.
// Registers: key words 0/1 at 0x00, 2/3 at 0x08, 4/5 at 0x10, 6/7 at 0x18,
// nonce at 0x20; all reset to zero. Write only while busy is low.

module chacha20_block_keystream
  #(parameter int ROUND_COUNT = chacha_pkg::DEFAULT_ROUND_COUNT)
   (input  wire logic                                 clock,
    input  wire logic                                 reset,
    // command channel
    input  wire logic                                 start,
    output      logic                                 busy,
    input  wire logic [63:0]                          req_block_number,
    // result channel
    output      logic                                 rsp_valid,
    output      logic [63:0]                          rsp_keystream_pair,
    output      logic [2:0]                           rsp_pair_index,
    output      logic                                 rsp_last_pair,
    // register port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [chacha_pkg::CSR_ADDR_BITS-1:0] paddr,
    input  wire logic [63:0]                          pwdata,
    output      logic [63:0]                          prdata,
    output      logic                                 pready);

   import chacha_pkg::*;

   localparam int RCW = $clog2(ROUND_COUNT + 1);

   // configuration registers
   logic [63:0] key01_ff, key23_ff, key45_ff, key67_ff, nonce_ff;
   logic [2:0]  reg_idx;
   logic        csr_wr;

   // sequencer state
   logic           busy_ff;
   step_type       step_ff, step_in;
   logic [RCW-1:0] round_left_ff;
   logic [2:0]     pair_cnt_ff;
   ctrl_type       ctrl;
   logic           jump_taken;
   logic           accept;

   // result register
   logic        rsp_valid_ff;
   logic [63:0] rsp_pair_ff;
   logic [2:0]  rsp_index_ff;
   logic        rsp_last_ff;

   // datapath words
   logic [31:0] working_ff [WORD_COUNT];
   logic [31:0] initial_ff [WORD_COUNT];
   logic [31:0] working_in [WORD_COUNT];
   logic [31:0] start_words [WORD_COUNT];

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign csr_wr  = psel && penable && pwrite && pready;
   assign accept  = start && !busy_ff;

   always_comb begin
      unique case (reg_idx)
         REG_KEY_0_1: prdata = key01_ff;
         REG_KEY_2_3: prdata = key23_ff;
         REG_KEY_4_5: prdata = key45_ff;
         REG_KEY_6_7: prdata = key67_ff;
         REG_NONCE:   prdata = nonce_ff;
         default:     prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff <= 64'd0;
         key23_ff <= 64'd0;
         key45_ff <= 64'd0;
         key67_ff <= 64'd0;
         nonce_ff <= 64'd0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_KEY_0_1: key01_ff <= pwdata;
            REG_KEY_2_3: key23_ff <= pwdata;
            REG_KEY_4_5: key45_ff <= pwdata;
            REG_KEY_6_7: key67_ff <= pwdata;
            REG_NONCE:   nonce_ff <= pwdata;
            default: ;  // unmapped, ignored
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Microcode sequencer. Step counter plus one conditional jump per word.
   // ---------------------------------------------------------------------
   assign ctrl = microcode(step_ff);

   always_comb begin
      unique case (ctrl.jump)
         JMP_ROUND_DONE: jump_taken = (round_left_ff == RCW'(1));
         JMP_ROUND_LEFT: jump_taken = (round_left_ff != RCW'(1));
         JMP_PAIR_LEFT:  jump_taken = (pair_cnt_ff != 3'(PAIR_COUNT - 1));
         default:        jump_taken = 1'b0;
      endcase
      step_in = jump_taken ? ctrl.target : step_ff + step_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         step_ff       <= STEP_COL_A;
         round_left_ff <= '0;
         pair_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               busy_ff       <= 1'b1;
               step_ff       <= STEP_COL_A;
               round_left_ff <= RCW'(ROUND_COUNT);
               pair_cnt_ff   <= '0;
            end
         end else begin
            step_ff <= step_in;
            if (ctrl.dec_round) begin
               round_left_ff <= round_left_ff - RCW'(1);
            end
            if (ctrl.op == OP_EMIT) begin
               rsp_valid_ff <= 1'b1;
               pair_cnt_ff  <= pair_cnt_ff + 3'd1;
            end
            if (ctrl.op == OP_FINISH) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // result payload: word pair sits at the bottom of the shifting state
   always_ff @(posedge clock) begin
      if (busy_ff && ctrl.op == OP_EMIT) begin
         rsp_pair_ff  <= {working_ff[1], working_ff[0]};
         rsp_index_ff <= pair_cnt_ff;
         rsp_last_ff  <= (pair_cnt_ff == 3'(PAIR_COUNT - 1));
      end
   end

   assign busy               = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keystream_pair = rsp_pair_ff;
   assign rsp_pair_index     = rsp_index_ff;
   assign rsp_last_pair      = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         start_words[i] = SIGMA_WORDS[i];
      end
      start_words[4]  = key01_ff[31:0];
      start_words[5]  = key01_ff[63:32];
      start_words[6]  = key23_ff[31:0];
      start_words[7]  = key23_ff[63:32];
      start_words[8]  = key45_ff[31:0];
      start_words[9]  = key45_ff[63:32];
      start_words[10] = key67_ff[31:0];
      start_words[11] = key67_ff[63:32];
      start_words[12] = req_block_number[31:0];
      start_words[13] = req_block_number[63:32];
      start_words[14] = nonce_ff[31:0];
      start_words[15] = nonce_ff[63:32];
   end

   // Four lanes, half a quarter-round each. Diagonal pass rotates rows b,c,d
   // by 1,2,3 lanes.
   always_comb begin
      logic [3:0]  ib, ic, id;
      logic [31:0] a, b, c, d, a1, b1, c1, d1, dx, bx;
      ib = '0;
      ic = '0;
      id = '0;
      a  = '0;
      b  = '0;
      c  = '0;
      d  = '0;
      a1 = '0;
      b1 = '0;
      c1 = '0;
      d1 = '0;
      dx = '0;
      bx = '0;
      working_in = working_ff;
      unique case (ctrl.op)
         OP_MIX_A, OP_MIX_B: begin
            for (int l = 0; l < LANE_COUNT; l++) begin
               ib = 4'(4  + ((l + (ctrl.diag ? 1 : 0)) & 3));
               ic = 4'(8  + ((l + (ctrl.diag ? 2 : 0)) & 3));
               id = 4'(12 + ((l + (ctrl.diag ? 3 : 0)) & 3));
               a  = working_ff[l];
               b  = working_ff[ib];
               c  = working_ff[ic];
               d  = working_ff[id];
               a1 = a + b;
               dx = d ^ a1;
               d1 = (ctrl.op == OP_MIX_A) ? {dx[15:0], dx[31:16]}
                                          : {dx[23:0], dx[31:24]};
               c1 = c + d1;
               bx = b ^ c1;
               b1 = (ctrl.op == OP_MIX_A) ? {bx[19:0], bx[31:20]}
                                          : {bx[24:0], bx[31:25]};
               working_in[l]  = a1;
               working_in[ib] = b1;
               working_in[ic] = c1;
               working_in[id] = d1;
            end
         end
         OP_FINAL: begin
            for (int i = 0; i < WORD_COUNT; i++) begin
               working_in[i] = working_ff[i] + initial_ff[i];
            end
         end
         OP_EMIT: begin
            // shift down one pair; the top pair is don't-care
            for (int i = 0; i < WORD_COUNT - 2; i++) begin
               working_in[i] = working_ff[i + 2];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         working_ff <= start_words;
         initial_ff <= start_words;
      end else if (busy_ff) begin
         working_ff <= working_in;
      end
   end

`ifndef SYNTH
   // every result word falls inside a busy window
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result word outside busy window");

   // words of one block come back to back with rising index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pair |=>
         rsp_valid && rsp_pair_index == $past(rsp_pair_index) + 3'd1)
      else $error("result words not consecutive");

   // nothing follows the last pair of a block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_pair |=> !rsp_valid)
      else $error("extra word after last pair");

   // a taken start enters the program at its first step with the full count
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && step_ff == STEP_COL_A &&
         round_left_ff == RCW'(ROUND_COUNT))
      else $error("sequencer not started correctly");
`endif

endmodule

`default_nettype wire
